[src/prr_pkg.sv]
// Package for the probability row reinforce block: types and constants.
package prr_pkg;

    localparam int unsigned PROB_W  = 17;
    localparam int unsigned FLOOR_W = 13;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned ROW_W   = 6;
    localparam int unsigned ENT_W   = 4;
    localparam int unsigned SUM_W   = 24;
    localparam int unsigned PROD_W  = 34;
    localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [FUNC_W-1:0] FUNC_WRITE     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REINFORCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ      = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED    = 2'd3;

    localparam logic CFG_FLOOR      = 1'b0;
    localparam logic CFG_ROW_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_TGT, ST_CHECK, ST_SUM_RD, ST_SUM_ACC, ST_DON_RD,
        ST_DON_DIV, ST_DON_WR, ST_CLAMP_WR, ST_TGT_WR, ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture input item, clear walk state
        logic rd_target;  // issue memory read of target entry
        logic rd_walk;    // issue memory read of walk entry
        logic take_tgt;   // register target value
        logic sum_acc;    // add walk entry to donor sum
        logic div_start;  // start share divide
        logic wr_walk;    // write donor result
        logic wr_clamp;   // write floor (or remainder at target)
        logic wr_target;  // write target + inc
        logic wr_plain;   // func 0 write
        logic step;       // advance walk index
        logic rst_walk;   // restart walk index
        logic set_read;   // result = target value
        logic set_clamp;  // result = remainder, flag 1
        logic set_reinf;  // result = target + inc
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic valid_cmd;  // row/entry in range for func
        logic over;       // target + inc exceeds top
        logic walk_last;  // walk index at n-1
        logic donor;      // walk entry is a donor
        logic sum_zero;
        logic div_done;
    } t_stat;

endpackage

[src/probability_row_reinforce.sv]
// Top level of the probability row reinforce block.
// Usage:
//   Items enter on s_axis (func, row_index, entry_index, value); one result
//   item per input leaves on m_axis (result_value, clamped). Config writes
//   use the cfg channel: index 0 probability floor, index 1 row_length,
//   only while the block is idle.
//   func 0 writes one entry, func 2 reads one, func 1 reinforces a target
//   entry across the first row_length entries of the row.
// Reinforce walks the row once to build the donor sum and once to give
//   up shares, with a bit-serial divide of the 34-bit product for each
//   donor. If target + inc exceeds the top, a floor-reset pass instead
//   writes the floor to each of the n entries and the remainder to the
//   target.
// One item is in flight at a time; s_axis_tready is high only when idle,
//   which is in the cycle after the result item is taken.
// Reset: control returns to idle; the table is undefined until written.
// Receiver stall: the result is held in its register, stable, until
//   m_axis_tready is high; no new item is taken meanwhile.
module probability_row_reinforce #(
    parameter int unsigned ROW_ENTRIES = 16,
    parameter int unsigned NUM_ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // func[1:0], row_index[7:2],
                                       // entry_index[11:8], value[28:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // result_value[16:0], clamped[17]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [prr_pkg::FLOOR_W-1:0] r_prob_floor;
    logic [prr_pkg::LEN_W-1:0]   r_row_length;
    prr_pkg::t_cmd  w_cmd;
    prr_pkg::t_stat w_stat;
    logic [prr_pkg::PROB_W-1:0]  w_result;
    logic                        w_clamped;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob_floor <= 13'd328;
            r_row_length <= 5'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prr_pkg::CFG_FLOOR:      r_prob_floor <= i_cfg_data[12:0];
                prr_pkg::CFG_ROW_LENGTH: r_row_length <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    prr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_func      (s_axis_tdata[1:0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    prr_datapath #(
        .ROW_ENTRIES (ROW_ENTRIES),
        .NUM_ROWS    (NUM_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_func       (s_axis_tdata[1:0]),
        .i_row        (s_axis_tdata[7:2]),
        .i_ent        (s_axis_tdata[11:8]),
        .i_value      (s_axis_tdata[28:12]),
        .i_prob_floor (r_prob_floor),
        .i_row_length (r_row_length),
        .o_result     (w_result),
        .o_clamped    (w_clamped)
    );

    assign m_axis_tdata = {6'd0, w_clamped, w_result};
endmodule

[src/prr_div.sv]
// Restoring divider, one quotient bit per cycle.
module prr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [prr_pkg::PROD_W-1:0] i_num,
    input  logic [prr_pkg::SUM_W-1:0]  i_den,
    output logic                       o_done,
    output logic [prr_pkg::PROD_W-1:0] o_quot
);
    localparam int unsigned CNT_W = $clog2(prr_pkg::PROD_W + 1);

    logic [prr_pkg::PROD_W-1:0] r_quot, n_quot;
    logic [prr_pkg::SUM_W:0]    r_rem, n_rem;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_busy, n_busy, r_done, n_done;
    logic [prr_pkg::SUM_W:0]    w_try;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try  = {r_rem[prr_pkg::SUM_W-1:0], r_quot[prr_pkg::PROD_W-1]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(prr_pkg::PROD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, i_den}) begin
                n_rem  = w_try - {1'b0, i_den};
                n_quot = {r_quot[prr_pkg::PROD_W-2:0], 1'b1};
            end else begin
                n_rem  = w_try;
                n_quot = {r_quot[prr_pkg::PROD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[src/prr_datapath.sv]
// Datapath: probability memory, sum, share divide, result register.
module prr_datapath #(
    parameter int unsigned ROW_ENTRIES = 16,
    parameter int unsigned NUM_ROWS    = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prr_pkg::t_cmd               i_cmd,
    output prr_pkg::t_stat              o_stat,
    input  logic [prr_pkg::FUNC_W-1:0]  i_func,
    input  logic [prr_pkg::ROW_W-1:0]   i_row,
    input  logic [prr_pkg::ENT_W-1:0]   i_ent,
    input  logic [prr_pkg::PROB_W-1:0]  i_value,
    input  logic [prr_pkg::FLOOR_W-1:0] i_prob_floor,
    input  logic [prr_pkg::LEN_W-1:0]   i_row_length,
    output logic [prr_pkg::PROB_W-1:0]  o_result,
    output logic                        o_clamped
);
    localparam int unsigned EW    = (ROW_ENTRIES > 1) ? $clog2(ROW_ENTRIES) : 1;
    localparam int unsigned RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int unsigned DEPTH = ROW_ENTRIES * NUM_ROWS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW    = $clog2(ROW_ENTRIES + 1);
    localparam int unsigned CW    = NW + 8;

    logic [prr_pkg::PROB_W-1:0] r_mem [DEPTH];
    logic [prr_pkg::PROB_W-1:0] r_rdata;

    logic [RW-1:0]              r_row;
    logic [EW-1:0]              r_tgt, r_walk;
    logic [prr_pkg::PROB_W-1:0] r_inc, r_tval, r_result;
    logic [prr_pkg::SUM_W-1:0]  r_sum;
    logic                       r_valid, r_clamped;
    logic [NW-1:0]              r_n;
    logic [prr_pkg::PROD_W-1:0] r_prod;

    logic [NW-1:0]              w_n;
    logic [prr_pkg::ENT_W:0]    w_ent_ext;
    logic                       w_row_ok;
    logic [prr_pkg::FLOOR_W+NW-1:0] w_fl;
    logic signed [prr_pkg::FLOOR_W+NW+1:0] w_top;
    logic [prr_pkg::PROB_W-1:0] w_rem;
    logic [AW-1:0]              w_addr_t, w_addr_w;
    logic                       w_div_done;
    logic [prr_pkg::PROD_W-1:0] w_quot;
    logic [prr_pkg::PROB_W-1:0] w_donor_new;
    logic [prr_pkg::PROB_W:0]   w_tsum;

    // Effective length, saturated to 2..ROW_ENTRIES.
    always_comb begin
        if (i_row_length < prr_pkg::LEN_W'(2))
            w_n = NW'(2);
        else if ({{CW{1'b0}}, i_row_length} > (CW + prr_pkg::LEN_W)'(ROW_ENTRIES))
            w_n = NW'(ROW_ENTRIES);
        else
            w_n = NW'(i_row_length);
    end

    assign w_ent_ext = {1'b0, i_ent};
    assign w_row_ok  = ({{RW{1'b0}}, i_row} < (RW + prr_pkg::ROW_W)'(NUM_ROWS));

    assign w_fl   = i_prob_floor * (r_n - 1'b1);
    assign w_top  = $signed({2'b00, prr_pkg::ONE_Q16[prr_pkg::PROB_W-1:0],
                             {(prr_pkg::FLOOR_W+NW-prr_pkg::PROB_W){1'b0}}} >>>
                            (prr_pkg::FLOOR_W+NW-prr_pkg::PROB_W))
                    - $signed({2'b00, w_fl});
    assign w_rem  = (w_top < 0) ? '0 : prr_pkg::PROB_W'(w_top);
    assign w_tsum = {1'b0, r_tval} + {1'b0, r_inc};

    assign w_addr_t = AW'(r_row) * AW'(ROW_ENTRIES) + AW'(r_tgt);
    assign w_addr_w = AW'(r_row) * AW'(ROW_ENTRIES) + AW'(r_walk);

    prr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_donor_new = (w_quot >= prr_pkg::PROD_W'(r_rdata)) ? '0
                       : r_rdata - prr_pkg::PROB_W'(w_quot);

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_plain)
            r_mem[w_addr_t] <= r_inc;
        else if (i_cmd.wr_walk)
            r_mem[w_addr_w] <= w_donor_new;
        else if (i_cmd.wr_clamp)
            r_mem[w_addr_w] <= (r_walk == r_tgt) ? w_rem
                                                 : prr_pkg::PROB_W'(i_prob_floor);
        else if (i_cmd.wr_target)
            r_mem[w_addr_t] <= w_tsum[prr_pkg::PROB_W-1:0];
        if (i_cmd.rd_target)
            r_rdata <= r_mem[w_addr_t];
        else if (i_cmd.rd_walk)
            r_rdata <= r_mem[w_addr_w];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row  <= RW'(i_row);
            r_tgt  <= EW'(i_ent);
            r_inc  <= i_value;
            r_n    <= w_n;
            r_sum  <= '0;
            r_valid <= w_row_ok && (
                ((i_func == prr_pkg::FUNC_WRITE || i_func == prr_pkg::FUNC_READ)
                 && ({{NW{1'b0}}, w_ent_ext} < (NW + prr_pkg::ENT_W + 1)'(ROW_ENTRIES)))
             || ((i_func == prr_pkg::FUNC_REINFORCE)
                 && ({{NW{1'b0}}, w_ent_ext} < (NW + prr_pkg::ENT_W + 1)'(w_n))));
        end
        if (i_cmd.take_tgt) r_tval <= r_rdata;
        if (i_cmd.sum_acc)  r_sum  <= r_sum + prr_pkg::SUM_W'(r_rdata);
        r_prod <= prr_pkg::PROD_W'(r_rdata) * prr_pkg::PROD_W'(r_inc);
        if (i_cmd.rst_walk || i_cmd.load) r_walk <= '0;
        else if (i_cmd.step)              r_walk <= r_walk + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_result  <= '0;
            r_clamped <= 1'b0;
        end else if (i_cmd.set_read) begin
            r_result <= r_rdata;
        end else if (i_cmd.set_clamp) begin
            r_result  <= w_rem;
            r_clamped <= 1'b1;
        end else if (i_cmd.set_reinf) begin
            r_result <= w_tsum[prr_pkg::PROB_W-1:0];
        end
    end

    assign o_stat.valid_cmd = r_valid;
    assign o_stat.over      = $signed({{(prr_pkg::FLOOR_W+NW+1-prr_pkg::PROB_W){1'b0}},
                                       w_tsum}) > w_top;
    assign o_stat.walk_last = ({{NW{1'b0}}, r_walk} == (EW + NW)'(r_n - 1'b1));
    assign o_stat.donor     = (r_walk != r_tgt)
                            && (r_rdata > prr_pkg::PROB_W'(i_prob_floor));
    assign o_stat.sum_zero  = (r_sum == '0);
    assign o_stat.div_done  = w_div_done;
    assign o_result  = r_result;
    assign o_clamped = r_clamped;
endmodule

[src/prr_ctrl.sv]
// Controller state machine for the probability row reinforce block.
module prr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [prr_pkg::FUNC_W-1:0] i_func,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output prr_pkg::t_cmd              o_cmd,
    input  prr_pkg::t_stat             i_stat
);
    prr_pkg::t_state r_state, n_state;
    logic [prr_pkg::FUNC_W-1:0] r_func;
    logic r_in_don;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= prr_pkg::ST_IDLE;
        else          r_state <= n_state;
        if (o_cmd.load) r_func <= i_func;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            prr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = prr_pkg::ST_RD_TGT;
                end
            end
            prr_pkg::ST_RD_TGT: begin
                if (!i_stat.valid_cmd) begin
                    n_state = prr_pkg::ST_OUT;
                end else if (r_func == prr_pkg::FUNC_WRITE) begin
                    o_cmd.wr_plain = 1'b1;
                    n_state = prr_pkg::ST_OUT;
                end else begin
                    o_cmd.rd_target = 1'b1;
                    n_state = prr_pkg::ST_CHECK;
                end
            end
            prr_pkg::ST_CHECK: begin
                o_cmd.take_tgt = 1'b1;
                if (r_func == prr_pkg::FUNC_READ) begin
                    o_cmd.set_read = 1'b1;
                    n_state = prr_pkg::ST_OUT;
                end else begin
                    n_state = prr_pkg::ST_SUM_RD;
                end
            end
            prr_pkg::ST_SUM_RD: begin
                // target value now registered
                if (i_stat.over) begin
                    n_state = prr_pkg::ST_CLAMP_WR;
                end else begin
                    o_cmd.rd_walk = 1'b1;
                    n_state = prr_pkg::ST_SUM_ACC;
                end
            end
            prr_pkg::ST_SUM_ACC: begin
                if (i_stat.donor) o_cmd.sum_acc = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.rst_walk = 1'b1;
                    n_state = prr_pkg::ST_DON_RD;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = prr_pkg::ST_SUM_RD;
                end
            end
            prr_pkg::ST_DON_RD: begin
                if (i_stat.sum_zero) begin
                    n_state = prr_pkg::ST_TGT_WR;
                end else begin
                    o_cmd.rd_walk = 1'b1;
                    n_state = prr_pkg::ST_DON_DIV;
                end
            end
            prr_pkg::ST_DON_DIV: begin
                // the product register loads here, then the divide starts
                if (!i_stat.donor) begin
                    if (i_stat.walk_last) begin
                        n_state = prr_pkg::ST_TGT_WR;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state = prr_pkg::ST_DON_RD;
                    end
                end else begin
                    n_state = prr_pkg::ST_DON_WR;
                end
            end
            prr_pkg::ST_DON_WR: begin
                if (r_in_don) o_cmd.div_start = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.wr_walk = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state = prr_pkg::ST_TGT_WR;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state = prr_pkg::ST_DON_RD;
                    end
                end
            end
            prr_pkg::ST_CLAMP_WR: begin
                o_cmd.wr_clamp = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.set_clamp = 1'b1;
                    n_state = prr_pkg::ST_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            prr_pkg::ST_TGT_WR: begin
                o_cmd.wr_target = 1'b1;
                o_cmd.set_reinf = 1'b1;
                n_state = prr_pkg::ST_OUT;
            end
            prr_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = prr_pkg::ST_IDLE;
            end
            default: n_state = prr_pkg::ST_IDLE;
        endcase
    end

    // Divide start is issued in the first cycle of ST_DON_WR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_don <= 1'b0;
        else          r_in_don <= (r_state == prr_pkg::ST_DON_DIV) && i_stat.donor;
    end

`ifndef SYNTH
    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == prr_pkg::ST_OUT)
        else $error("result offered outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("item accepted while result pending");
    a_wr_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.wr_plain, o_cmd.wr_walk, o_cmd.wr_clamp, o_cmd.wr_target}) <= 1)
        else $error("two memory writes in one cycle");
`endif
endmodule
